[design/msfrc_pkg.sv]
// shared types and constants of the mark-sweep page sweeper
// no dependencies; used by the interfaces and every module of the block
package msfrc_pkg;

    localparam int unsigned BASE_W = 48;
    localparam int unsigned SIZE_W = 19;

    localparam int unsigned PAGE_BYTES = 262144;
    localparam int unsigned SIZE_MAX   = (1 << SIZE_W) - 1;
    // a dead run never grows past one page or past its field
    localparam logic [SIZE_W-1:0] RUN_CAP =
        SIZE_W'((PAGE_BYTES < SIZE_MAX) ? PAGE_BYTES : SIZE_MAX);

    typedef struct packed {
        logic              first_object;
        logic [BASE_W-1:0] page_base;
        logic [SIZE_W-1:0] object_size;
        logic              marked;
        logic              last_object;
        logic              executable_page;
        logic              image_page;
    } t_hdr;

    typedef struct packed {
        logic              clear_mark;
        logic              run_valid;
        logic [BASE_W-1:0] run_address;
        logic [SIZE_W-1:0] run_bytes;
        logic              add_to_free_list;
        logic              fill_with_trap;   // fill with trap byte 0xcc
        logic              page_done;
        logic              page_live;
    } t_res;

endpackage

[design/msfrc_if.sv]
// valid/ready channel interfaces of the page sweeper
// depends on msfrc_pkg for the header and result types
interface msfrc_hdr_if;
    logic              valid;
    logic              ready;
    msfrc_pkg::t_hdr   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msfrc_res_if;
    logic              valid;
    logic              ready;
    msfrc_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/msfrc_in_reg.sv]
// input register stage of the page sweeper: holds one header transaction
// depends on msfrc_pkg and msfrc_if
module msfrc_in_reg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msfrc_hdr_if.sink    i_hdr,
    msfrc_hdr_if.source  o_hdr
);

    logic            r_valid;
    msfrc_pkg::t_hdr r_data;

    // take a new transaction when empty or when the held one moves on
    assign i_hdr.ready = !r_valid || o_hdr.ready;
    assign o_hdr.valid = r_valid;
    assign o_hdr.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_valid <= i_hdr.valid;
        end
        if (i_hdr.valid && i_hdr.ready) begin
            r_data <= i_hdr.data;
        end
    end

endmodule

[design/msfrc_sweep.sv]
// sweep stage: page state, dead-run merging and the result register
// depends on msfrc_pkg and msfrc_if
module msfrc_sweep #(
    parameter int unsigned ADDRESS_BITS = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msfrc_hdr_if.sink    i_hdr,
    msfrc_res_if.source  o_res
);

    localparam int unsigned SW = msfrc_pkg::SIZE_W;

    // page state
    logic [ADDRESS_BITS-1:0] r_next_addr,   n_next_addr;
    logic                    r_run_open,    n_run_open;
    logic [ADDRESS_BITS-1:0] r_run_start,   n_run_start;
    logic [SW-1:0]           r_run_len,     n_run_len;
    logic                    r_run_from_pg, n_run_from_pg;
    logic                    r_live_seen,   n_live_seen;
    logic                    r_page_exec,   n_page_exec;
    logic                    r_page_image,  n_page_image;

    logic                    r_out_valid;
    msfrc_pkg::t_res         r_out,         n_out;

    logic                    accept;
    logic                    close;
    logic                    whole;
    logic [SW:0]             len_sum;
    logic [63:0]             start_wide;
    msfrc_pkg::t_hdr         hdr;

    assign hdr         = i_hdr.data;
    assign i_hdr.ready = !r_out_valid || o_res.ready;
    assign accept      = i_hdr.valid && i_hdr.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_next_addr   = r_next_addr;
        n_run_open    = r_run_open;
        n_run_start   = r_run_start;
        n_run_len     = r_run_len;
        n_run_from_pg = r_run_from_pg;
        n_live_seen   = r_live_seen;
        n_page_exec   = r_page_exec;
        n_page_image  = r_page_image;
        n_out         = '0;
        close         = 1'b0;
        whole         = 1'b0;
        len_sum       = '0;
        start_wide    = '0;

        // a first header starts a fresh page and drops any open run
        if (hdr.first_object) begin
            n_next_addr   = ADDRESS_BITS'(hdr.page_base);
            n_run_open    = 1'b0;
            n_run_len     = '0;
            n_run_from_pg = 1'b0;
            n_live_seen   = 1'b0;
            n_page_exec   = hdr.executable_page;
            n_page_image  = hdr.image_page;
        end

        if (!n_page_image) begin
            if (hdr.marked) begin
                n_out.clear_mark = 1'b1;
                n_live_seen      = 1'b1;
                close            = n_run_open;
            end else begin
                if (!n_run_open) begin
                    n_run_open    = 1'b1;
                    n_run_start   = n_next_addr;
                    n_run_len     = '0;
                    n_run_from_pg = hdr.first_object;
                end
                len_sum = {1'b0, n_run_len} + {1'b0, hdr.object_size};
                // saturate at the page size
                if (len_sum > {1'b0, msfrc_pkg::RUN_CAP}) begin
                    n_run_len = msfrc_pkg::RUN_CAP;
                end else begin
                    n_run_len = len_sum[SW-1:0];
                end
                if (hdr.last_object) begin
                    close = 1'b1;
                    whole = n_run_from_pg;
                end
            end
            if (close) begin
                start_wide             = 64'(n_run_start);
                n_out.run_valid        = 1'b1;
                n_out.run_address      = start_wide[msfrc_pkg::BASE_W-1:0];
                n_out.run_bytes        = n_run_len;
                n_out.add_to_free_list = !whole;
                n_out.fill_with_trap   = n_page_exec;
                n_run_open             = 1'b0;
                n_run_len              = '0;
                n_run_from_pg          = 1'b0;
            end
        end

        n_next_addr = n_next_addr + ADDRESS_BITS'(hdr.object_size);

        if (hdr.last_object) begin
            n_out.page_done = 1'b1;
            n_out.page_live = n_live_seen || n_page_image;
            n_run_open      = 1'b0;
            n_run_len       = '0;
            n_run_from_pg   = 1'b0;
            n_live_seen     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_addr   <= '0;
            r_run_open    <= 1'b0;
            r_run_start   <= '0;
            r_run_len     <= '0;
            r_run_from_pg <= 1'b0;
            r_live_seen   <= 1'b0;
            r_page_exec   <= 1'b0;
            r_page_image  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_next_addr   <= n_next_addr;
                r_run_open    <= n_run_open;
                r_run_start   <= n_run_start;
                r_run_len     <= n_run_len;
                r_run_from_pg <= n_run_from_pg;
                r_live_seen   <= n_live_seen;
                r_page_exec   <= n_page_exec;
                r_page_image  <= n_page_image;
            end
            if (i_hdr.ready) begin
                r_out_valid <= i_hdr.valid;
            end
        end
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

[design/mark_sweep_free_run_coalescer_top.sv]
// top level of the mark-sweep page sweeper with dead-run merging
// depends on msfrc_pkg, msfrc_if, msfrc_in_reg and msfrc_sweep
//
// i_hdr takes object headers of a heap page in address order, one
// transaction each; o_res gives exactly one result transaction per header:
// the mark-clear order, a closed dead run with its free-list and trap-fill
// flags, and on the page's last object the page done / in use status.
// Each header passes through the input register, then through the sweep
// logic into the result register, which raises result valid. Throughput
// is one header per cycle while o_res does not stall; the page state in
// the sweep stage is updated as each header is taken.
// Reset (synchronous, active low) empties both registers and zeroes the
// page state. When o_res stalls, the result register holds its data and
// the input register takes at most one more header if it is empty, after
// which i_hdr.ready drops until o_res moves again; nothing is lost or repeated.
module mark_sweep_free_run_coalescer_top #(
    parameter int unsigned ADDRESS_BITS = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msfrc_hdr_if.sink    i_hdr,
    msfrc_res_if.source  o_res
);

    msfrc_hdr_if hdr_q ();

    msfrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (i_hdr),
        .o_hdr   (hdr_q.source)
    );

    msfrc_sweep #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_q.sink),
        .o_res   (o_res)
    );

endmodule
